// File: design/akhc_pkg.sv
// Package for the AT keyboard host controller: payload structs, phase and
// command codes, classified transaction type and the odd-parity helper.
// No dependencies.
package akhc_pkg;

   localparam int FRAME_WIDTH    = 11;
   localparam int BYTE_WIDTH     = 8;
   localparam int ID_WIDTH       = 16;
   localparam int LED_WIDTH      = 3;
   localparam int STALL_WIDTH    = 3;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] FUNC_FRAME = 2'd0;
   localparam logic [1:0] FUNC_POLL  = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_ADDR_TERMINAL_SET3 = 3'd0;

   localparam logic [BYTE_WIDTH-1:0] BYTE_SELFTEST_OK = 8'hAA;
   localparam logic [BYTE_WIDTH-1:0] BYTE_ACK         = 8'hFA;
   localparam logic [BYTE_WIDTH-1:0] BYTE_RESET       = 8'hFF;
   localparam logic [BYTE_WIDTH-1:0] BYTE_RESEND      = 8'hFE;
   localparam logic [BYTE_WIDTH-1:0] BYTE_READ_ID     = 8'hF2;
   localparam logic [BYTE_WIDTH-1:0] BYTE_SET_LEDS    = 8'hED;
   localparam logic [BYTE_WIDTH-1:0] BYTE_MAKE_BREAK  = 8'hF8;
   localparam logic [BYTE_WIDTH-1:0] BYTE_POWER_ON    = 8'h54;
   localparam logic [ID_WIDTH-1:0]   ID_UNKNOWN       = 16'hFFFF;

   localparam logic [STALL_WIDTH-1:0] STALL_MAX        = 3'd7;
   localparam logic [STALL_WIDTH-1:0] STALL_ID_LIMIT   = 3'd2;
   localparam logic [STALL_WIDTH-1:0] STALL_LINK_LIMIT = 3'd5;

   typedef enum logic [2:0] {
      PH_UNINIT         = 3'd0,
      PH_AWAIT_ACK      = 3'd1,
      PH_AWAIT_SELFTEST = 3'd2,
      PH_READ_ID_1      = 3'd3,
      PH_READ_ID_2      = 3'd4,
      PH_SETUP          = 3'd5,
      PH_SET_LEDS       = 3'd6,
      PH_READY          = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      CLS_NONE,
      CLS_FRAME_OK,
      CLS_PARITY_ERR,
      CLS_LINK_ERR,
      CLS_POLL,
      CLS_TICK
   } class_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_RESET,
      CMD_RESEND,
      CMD_READ_ID,
      CMD_MAKE_BREAK,
      CMD_SET_LEDS,
      CMD_LED_DATA
   } cmd_type;

   typedef enum logic [1:0] {
      FERR_NONE      = 2'd0,
      FERR_PARITY    = 2'd1,
      FERR_START_STOP = 2'd2
   } ferr_type;

   typedef struct packed {
      logic [1:0]             func;
      logic [FRAME_WIDTH-1:0] frame;
      logic                   clock_high;
      logic [LED_WIDTH-1:0]   lock_leds;
   } req_type;

   typedef struct packed {
      logic                  send_valid;
      logic [BYTE_WIDTH:0]   send_word;
      logic                  key_valid;
      logic [BYTE_WIDTH-1:0] key_code;
      logic [1:0]            frame_error;
      logic                  link_restarted;
      logic [ID_WIDTH-1:0]   kbd_id;
      logic                  ready_res;
   } rsp_type;

   typedef struct packed {
      class_type             kind;
      logic [BYTE_WIDTH-1:0] data;
      logic                  power_on;
      logic                  clock_high;
      logic [LED_WIDTH-1:0]  lock_leds;
   } item_type;

   function automatic logic odd_parity(input logic [BYTE_WIDTH-1:0] b);
      odd_parity = ~^b;
   endfunction

endpackage

// File: design/akhc_front.sv
// Front end of the AT keyboard host controller: checks frame framing and
// parity and classifies each incoming transaction. Depends on akhc_pkg.
module akhc_front (
   input  akhc_pkg::req_type  req,
   output akhc_pkg::item_type item
);
   import akhc_pkg::*;

   logic [BYTE_WIDTH-1:0] data;
   logic                  par_bad;
   logic                  frame_bad;

   assign data      = req.frame[BYTE_WIDTH:1];
   assign par_bad   = req.frame[BYTE_WIDTH+1] != odd_parity(data);
   assign frame_bad = req.frame[0] || !req.frame[FRAME_WIDTH-1];

   always_comb begin
      item.data       = data;
      item.power_on   = (data == BYTE_POWER_ON) && req.frame[BYTE_WIDTH+1];
      item.clock_high = req.clock_high;
      item.lock_leds  = req.lock_leds;
      unique case (req.func)
         FUNC_FRAME: begin
            if (par_bad) begin
               item.kind = CLS_PARITY_ERR;
            end else if (frame_bad) begin
               item.kind = CLS_LINK_ERR;
            end else begin
               item.kind = CLS_FRAME_OK;
            end
         end
         FUNC_POLL: item.kind = CLS_POLL;
         FUNC_TICK: item.kind = CLS_TICK;
         default:   item.kind = CLS_NONE;
      endcase
   end

endmodule

// File: design/akhc_queue.sv
// Two-entry queue of classified transactions between front and back end.
// Depends on akhc_pkg.
module akhc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  akhc_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output akhc_pkg::item_type head_item
);
   import akhc_pkg::*;

   item_type                   entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;

   assign full       = count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: design/akhc_back.sv
// Back end of the AT keyboard host controller: link set-up state machine,
// stall handling, LED updates and the registered result. Depends on akhc_pkg.
module akhc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               terminal_set3,
   input  logic               item_valid,
   input  akhc_pkg::item_type item,
   output logic               item_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output akhc_pkg::rsp_type  rsp_payload
);
   import akhc_pkg::*;

   phase_type              phase_ff, phase_in;
   logic                   retried_ff, retried_in;
   logic [ID_WIDTH-1:0]    id_ff, id_in;
   logic [LED_WIDTH-1:0]   leds_ff, leds_in;
   logic [STALL_WIDTH-1:0] stall_ff, stall_in;
   logic [STALL_WIDTH-1:0] stall_inc;
   cmd_type                cmd;
   logic                   restarted;

   logic                   rsp_valid_ff;
   rsp_type                rsp_ff, rsp_in;
   logic [BYTE_WIDTH-1:0]  cmd_byte;

   assign item_pop    = item_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign stall_inc   = (stall_ff < STALL_MAX) ? stall_ff + 1'b1 : stall_ff;

   // next state
   always_comb begin
      phase_in   = phase_ff;
      retried_in = retried_ff;
      id_in      = id_ff;
      leds_in    = leds_ff;
      stall_in   = stall_ff;
      cmd        = CMD_NONE;
      restarted  = 1'b0;
      unique case (item.kind) inside
         CLS_PARITY_ERR: begin
            cmd = CMD_RESEND;
            if (item.power_on) begin
               phase_in   = PH_UNINIT;
               retried_in = 1'b0;
               restarted  = 1'b1;
            end
         end
         CLS_LINK_ERR: begin
            phase_in   = PH_UNINIT;
            retried_in = 1'b0;
            restarted  = 1'b1;
         end
         CLS_FRAME_OK: begin
            unique case (phase_ff)
               PH_UNINIT: begin
                  retried_in = 1'b0;
                  id_in      = ID_UNKNOWN;
                  if (item.data == BYTE_SELFTEST_OK) begin
                     leds_in  = '0;
                     phase_in = PH_READ_ID_1;
                  end else begin
                     phase_in = PH_AWAIT_ACK;
                     cmd      = CMD_RESET;
                  end
               end
               PH_AWAIT_ACK: begin
                  if (item.data == BYTE_ACK) begin
                     phase_in = PH_AWAIT_SELFTEST;
                  end else begin
                     cmd = CMD_RESET;
                  end
               end
               PH_AWAIT_SELFTEST: begin
                  if (item.data == BYTE_SELFTEST_OK) begin
                     leds_in  = '0;
                     phase_in = PH_READ_ID_1;
                  end else begin
                     phase_in = PH_AWAIT_ACK;
                     cmd      = CMD_RESET;
                  end
               end
               PH_READ_ID_1: begin
                  if (item.data != BYTE_ACK) begin
                     id_in    = {item.data, id_ff[BYTE_WIDTH-1:0]};
                     phase_in = PH_READ_ID_2;
                  end
               end
               PH_READ_ID_2: begin
                  id_in = {id_ff[ID_WIDTH-1:BYTE_WIDTH], item.data};
                  if (terminal_set3) begin
                     cmd      = CMD_MAKE_BREAK;
                     phase_in = PH_SETUP;
                  end else begin
                     phase_in = PH_READY;
                  end
               end
               PH_SETUP: begin
                  if (item.data != BYTE_ACK) begin
                     id_in = ID_UNKNOWN;
                  end
                  phase_in = PH_READY;
               end
               PH_SET_LEDS: begin
                  if (item.data == BYTE_ACK) begin
                     if (item.lock_leds != leds_ff) begin
                        leds_in = item.lock_leds;
                        cmd     = CMD_LED_DATA;
                     end else begin
                        phase_in = PH_READY;
                     end
                  end else begin
                     leds_in  = item.lock_leds;
                     phase_in = PH_READY;
                  end
               end
               default: begin
               end
            endcase
         end
         CLS_POLL, CLS_TICK: begin
            if (phase_ff == PH_READY) begin
               stall_in = '0;
               if (item.lock_leds != leds_ff) begin
                  phase_in = PH_SET_LEDS;
                  cmd      = CMD_SET_LEDS;
               end
            end else if (item.kind == CLS_TICK && item.clock_high) begin
               stall_in = stall_inc;
               if (phase_ff == PH_READ_ID_1 || phase_ff == PH_READ_ID_2 ||
                   phase_ff == PH_SETUP) begin
                  if (stall_inc > STALL_ID_LIMIT) begin
                     stall_in = '0;
                     if (!retried_ff) begin
                        retried_in = 1'b1;
                        phase_in   = PH_READ_ID_1;
                        cmd        = CMD_READ_ID;
                     end else begin
                        id_in    = ID_UNKNOWN;
                        phase_in = PH_READY;
                     end
                  end
               end else if (phase_ff == PH_SET_LEDS) begin
                  if (stall_inc > STALL_ID_LIMIT) begin
                     stall_in = '0;
                     phase_in = PH_READY;
                  end
               end else if (stall_inc >= STALL_LINK_LIMIT) begin
                  stall_in = '0;
                  phase_in = PH_AWAIT_ACK;
                  cmd      = CMD_RESET;
               end
            end else if (item.kind == CLS_TICK && phase_ff == PH_UNINIT) begin
               stall_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      unique case (cmd)
         CMD_RESET:      cmd_byte = BYTE_RESET;
         CMD_RESEND:     cmd_byte = BYTE_RESEND;
         CMD_READ_ID:    cmd_byte = BYTE_READ_ID;
         CMD_MAKE_BREAK: cmd_byte = BYTE_MAKE_BREAK;
         CMD_SET_LEDS:   cmd_byte = BYTE_SET_LEDS;
         CMD_LED_DATA:   cmd_byte = BYTE_WIDTH'(item.lock_leds);
         default:        cmd_byte = '0;
      endcase
      rsp_in.send_valid     = cmd != CMD_NONE;
      rsp_in.send_word      = (cmd != CMD_NONE) ? {odd_parity(cmd_byte), cmd_byte} : '0;
      rsp_in.key_valid      = (item.kind == CLS_FRAME_OK) && (phase_ff == PH_READY);
      rsp_in.key_code       = rsp_in.key_valid ? item.data : '0;
      rsp_in.frame_error    = (item.kind == CLS_PARITY_ERR) ? FERR_PARITY :
                              (item.kind == CLS_LINK_ERR)   ? FERR_START_STOP : FERR_NONE;
      rsp_in.link_restarted = restarted;
      rsp_in.kbd_id         = id_in;
      rsp_in.ready_res      = phase_in == PH_READY;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_UNINIT;
         retried_ff   <= 1'b0;
         id_ff        <= ID_UNKNOWN;
         leds_ff      <= '0;
         stall_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (item_pop) begin
            phase_ff   <= phase_in;
            retried_ff <= retried_in;
            id_ff      <= id_in;
            leds_ff    <= leds_in;
            stall_ff   <= stall_in;
         end
         if (item_pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: design/at_keyboard_host_controller_core.sv
// Top level of the AT keyboard host controller: configuration register,
// front classifier, transaction queue and back end. Depends on akhc_pkg,
// akhc_front, akhc_queue and akhc_back.
//
// Usage: each req transaction is one event (received frame, service poll or
// 200 ms stall tick). Every transaction gives exactly one rsp transaction,
// in order, carrying the command byte to send, a scancode, frame errors,
// link restart, the keyboard ID and the initialised flag.
// Path: an accepted transaction is written into the queue; the back end
// then pops it, updates its state and registers the result offered on rsp.
// Throughput: one transaction per cycle while rsp is not stalled by a low
// rsp_ready. A two-entry queue separates classification from the state
// machine, so req keeps accepting while a result waits; when rsp_ready
// stays low the queue fills and req_ready drops after two more transactions.
// Reset (synchronous) returns the link to uninitialised with ID 0xFFFF and
// clears terminal_set3; no clearing pass is needed. terminal_set3 sits at
// APB byte address 0. Write it only while idle; the block does not check.
module at_keyboard_host_controller_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  akhc_pkg::req_type                     req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output akhc_pkg::rsp_type                     rsp_payload,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [akhc_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [akhc_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [akhc_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                  pready
);
   import akhc_pkg::*;

   logic     set3_ff, set3_in;
   logic     csr_write;
   logic     queue_full;
   logic     push;
   logic     pop;
   logic     head_valid;
   item_type front_item;
   item_type head_item;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready &&
                      (paddr[CSR_ADDR_WIDTH-1:2] == CSR_ADDR_TERMINAL_SET3[CSR_ADDR_WIDTH-1:2]);
   assign set3_in   = csr_write ? pwdata[0] : set3_ff;
   assign prdata    = (paddr[CSR_ADDR_WIDTH-1:2] == CSR_ADDR_TERMINAL_SET3[CSR_ADDR_WIDTH-1:2]) ?
                      CSR_DATA_WIDTH'(set3_ff) : '0;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         set3_ff <= 1'b0;
      end else begin
         set3_ff <= set3_in;
      end
   end

   akhc_front u_front (
      .req  (req_payload),
      .item (front_item)
   );

   akhc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (front_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   akhc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .terminal_set3 (set3_ff),
      .item_valid    (head_valid),
      .item          (head_item),
      .item_pop      (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload)
   );

endmodule
